/* sv/mcc_pkg.sv */
// Package: payload types and constants for the collision cost block.
`timescale 1ns / 1ps
package mcc_pkg;
   localparam int MAX_STEPS = 256;
   localparam int FRAC_BITS = 16;
   localparam int SUM_W = 48;
   localparam logic [SUM_W-1:0] MAX48 = {SUM_W{1'b1}};
   localparam logic [23:0] WEIGHT_RESET = 24'd65536;

   typedef struct packed {
      logic [7:0] step_index;
      logic [8:0] path_length;
      logic signed [31:0] traj_x;
      logic signed [31:0] traj_y;
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic signed [31:0] cov_xx;
      logic signed [31:0] cov_xy;
      logic signed [31:0] cov_yx;
      logic signed [31:0] cov_yy;
      logic last;
   } req_type;

   typedef struct packed {
      logic [47:0] total_cost;
      logic [47:0] weighted_cost;
      logic saturated;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic active;
      logic [8:0] num_k;
      logic [8:0] den_n;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [31:0] cxx;
      logic signed [31:0] cxy;
      logic signed [31:0] cyx;
      logic signed [31:0] cyy;
      logic last;
   } job_type;
endpackage

/* sv/mcc_front.sv */
// Front end: accepts transactions, classifies step range, queues jobs.
`timescale 1ns / 1ps
module mcc_front import mcc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   output logic job_valid,
   input  logic job_take,
   output job_type job
);
   localparam int DEPTH = 2;
   job_type q_ff [DEPTH];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   job_type j;
   logic [8:0] n;
   logic push_ok, pop_ok;

   always_comb begin
      n = (req_data.path_length > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : req_data.path_length;
      j.active = (req_data.step_index != 8'd0) && ({1'b0, req_data.step_index} < n);
      j.num_k = n - {1'b0, req_data.step_index};
      j.den_n = n;
      j.dx = 33'(req_data.traj_x) - 33'(req_data.mean_x);
      j.dy = 33'(req_data.traj_y) - 33'(req_data.mean_y);
      j.cxx = req_data.cov_xx;
      j.cxy = req_data.cov_xy;
      j.cyx = req_data.cov_yx;
      j.cyy = req_data.cov_yy;
      j.last = req_data.last;
   end

   assign req_full = (cnt_ff == 2'(DEPTH));
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rp_ff];
   assign push_ok = req_push && !req_full;
   assign pop_ok = job_take && job_valid;

   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wp_ff] <= j;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_ok) wp_ff <= wp_ff + 1'b1;
         if (pop_ok) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push_ok) - 2'(pop_ok);
      end
   end
endmodule

/* sv/mcc_back.sv */
// Back end: shared 32x33 multiply sequence, 128-bit restoring divide, accumulate, weight.
`timescale 1ns / 1ps
module mcc_back import mcc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_take,
   input  job_type job,
   input  logic [23:0] weight,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_MUL, S_POST, S_CHK, S_DIV, S_QUO, S_ACC, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_DET1, OP_DET2, OP_SQX, OP_Q1, OP_SQY, OP_Q3, OP_PXY, OP_Q2, OP_NUM, OP_DEN,
      OP_WGT
   } op_type;

   state_type st_ff;
   op_type op_ff;
   job_type jb_ff;
   logic [63:0] sq_ff;
   logic [127:0] det_ff, q_ff;
   logic [127:0] num_ff, den_ff, quo_ff, rem_ff;
   logic [127:0] ma_ff, macc_ff;
   logic [32:0] mb_ff;
   logic [1:0] mcnt_ff, mlast_ff;
   logic msign_ff;
   logic [6:0] bit_ff;
   logic [47:0] sum_ff, term_ff;
   logic sat_ff, flag_ff;
   logic [71:0] wp_ff;
   rsp_type out_ff;
   logic full_ff, full_in;

   logic [31:0] mdx, mdy, mcxx, mcxy, mcyx, mcyy, mchunk;
   logic signed [32:0] cs;
   logic [32:0] mcs;
   logic [127:0] op_a;
   logic [32:0] op_b;
   logic op_sign;
   logic [1:0] op_last;
   logic [64:0] pp;
   logic [127:0] mprod, r_sh, aq;
   logic [63:0] ad;
   logic [48:0] sum_w;
   logic out_load;

   assign mdx = jb_ff.dx[32] ? 32'(-jb_ff.dx) : 32'(jb_ff.dx);
   assign mdy = jb_ff.dy[32] ? 32'(-jb_ff.dy) : 32'(jb_ff.dy);
   assign mcxx = jb_ff.cxx[31] ? -jb_ff.cxx : jb_ff.cxx;
   assign mcxy = jb_ff.cxy[31] ? -jb_ff.cxy : jb_ff.cxy;
   assign mcyx = jb_ff.cyx[31] ? -jb_ff.cyx : jb_ff.cyx;
   assign mcyy = jb_ff.cyy[31] ? -jb_ff.cyy : jb_ff.cyy;
   assign cs = 33'(jb_ff.cxy) + 33'(jb_ff.cyx);
   assign mcs = cs[32] ? -cs : cs;

   assign mchunk = ma_ff[{mcnt_ff, 5'd0} +: 32];
   assign pp = 65'(mchunk) * 65'(mb_ff);
   assign mprod = msign_ff ? -macc_ff : macc_ff;
   assign r_sh = {rem_ff[126:0], num_ff[bit_ff]};
   assign aq = q_ff[127] ? -q_ff : q_ff;
   assign ad = det_ff[127] ? 64'(-det_ff) : det_ff[63:0];
   assign sum_w = {1'b0, sum_ff} + {1'b0, term_ff};
   assign job_take = (st_ff == S_IDLE) && job_valid;
   assign rsp_empty = !full_ff;
   assign rsp_data = out_ff;
   assign out_load = (st_ff == S_OUT) && (!full_ff || rsp_pop);

   always_comb begin
      full_in = full_ff;
      if (rsp_pop && full_ff) full_in = 1'b0;
      if (out_load) full_in = 1'b1;
   end

   // operand select; op_last is the index of the top 32-bit chunk of op_a
   always_comb begin
      op_a = '0;
      op_b = '0;
      op_sign = 1'b0;
      op_last = 2'd0;
      unique case (op_ff)
         OP_DET1: begin
            op_a = 128'(mcxx);
            op_b = 33'(mcyy);
            op_sign = jb_ff.cxx[31] ^ jb_ff.cyy[31];
         end
         OP_DET2: begin
            op_a = 128'(mcxy);
            op_b = 33'(mcyx);
            op_sign = ~(jb_ff.cxy[31] ^ jb_ff.cyx[31]);
         end
         OP_SQX: begin
            op_a = 128'(mdx);
            op_b = 33'(mdx);
         end
         OP_Q1: begin
            op_a = 128'(sq_ff);
            op_b = 33'(mcyy);
            op_sign = jb_ff.cyy[31];
            op_last = 2'd1;
         end
         OP_SQY: begin
            op_a = 128'(mdy);
            op_b = 33'(mdy);
         end
         OP_Q3: begin
            op_a = 128'(sq_ff);
            op_b = 33'(mcxx);
            op_sign = jb_ff.cxx[31];
            op_last = 2'd1;
         end
         OP_PXY: begin
            op_a = 128'(mdx);
            op_b = 33'(mdy);
         end
         OP_Q2: begin
            op_a = 128'(sq_ff);
            op_b = mcs;
            op_sign = ~(jb_ff.dx[32] ^ jb_ff.dy[32] ^ cs[32]);
            op_last = 2'd1;
         end
         OP_NUM: begin
            op_a = 128'(ad);
            op_b = 33'(jb_ff.num_k);
            op_last = 2'd1;
         end
         OP_DEN: begin
            op_a = aq;
            op_b = 33'(jb_ff.den_n);
            op_last = 2'd3;
         end
         OP_WGT: begin
            op_a = 128'(sum_ff);
            op_b = 33'(weight);
            op_last = 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         op_ff <= OP_DET1;
         sum_ff <= '0;
         sat_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         unique case (st_ff)
            S_IDLE: if (job_valid) begin
               jb_ff <= job;
               term_ff <= '0;
               flag_ff <= 1'b0;
               op_ff <= OP_DET1;
               st_ff <= job.active ? S_LOAD : S_ACC;
            end
            S_LOAD: begin
               ma_ff <= op_a;
               mb_ff <= op_b;
               msign_ff <= op_sign;
               mlast_ff <= op_last;
               mcnt_ff <= '0;
               macc_ff <= '0;
               st_ff <= S_MUL;
            end
            S_MUL: begin
               macc_ff <= macc_ff + (128'(pp) << {mcnt_ff, 5'd0});
               mcnt_ff <= mcnt_ff + 2'd1;
               if (mcnt_ff == mlast_ff) st_ff <= S_POST;
            end
            S_POST: begin
               unique case (op_ff)
                  OP_DET1: begin
                     det_ff <= mprod;
                     op_ff <= OP_DET2;
                     st_ff <= S_LOAD;
                  end
                  OP_DET2: begin
                     det_ff <= det_ff + mprod;
                     op_ff <= OP_SQX;
                     st_ff <= S_LOAD;
                  end
                  OP_SQX: begin
                     sq_ff <= macc_ff[63:0];
                     op_ff <= OP_Q1;
                     st_ff <= S_LOAD;
                  end
                  OP_Q1: begin
                     q_ff <= mprod;
                     op_ff <= OP_SQY;
                     st_ff <= S_LOAD;
                  end
                  OP_SQY: begin
                     sq_ff <= macc_ff[63:0];
                     op_ff <= OP_Q3;
                     st_ff <= S_LOAD;
                  end
                  OP_Q3: begin
                     q_ff <= q_ff + mprod;
                     op_ff <= OP_PXY;
                     st_ff <= S_LOAD;
                  end
                  OP_PXY: begin
                     sq_ff <= macc_ff[63:0];
                     op_ff <= OP_Q2;
                     st_ff <= S_LOAD;
                  end
                  OP_Q2: begin
                     q_ff <= q_ff + mprod;
                     st_ff <= S_CHK;
                  end
                  OP_NUM: begin
                     num_ff <= macc_ff << FRAC_BITS;
                     op_ff <= OP_DEN;
                     st_ff <= S_LOAD;
                  end
                  OP_DEN: begin
                     den_ff <= macc_ff;
                     rem_ff <= '0;
                     quo_ff <= '0;
                     bit_ff <= 7'd127;
                     st_ff <= S_DIV;
                  end
                  OP_WGT: begin
                     wp_ff <= macc_ff[71:0];
                     st_ff <= S_OUT;
                  end
                  default: st_ff <= S_IDLE;
               endcase
            end
            S_CHK: begin
               if (det_ff == '0) begin
                  flag_ff <= 1'b1;
                  st_ff <= S_ACC;
               end else if (q_ff == '0) begin
                  flag_ff <= 1'b1;
                  term_ff <= MAX48;
                  st_ff <= S_ACC;
               end else begin
                  op_ff <= OP_NUM;
                  st_ff <= S_LOAD;
               end
            end
            S_DIV: begin
               if (r_sh >= den_ff) begin
                  rem_ff <= r_sh - den_ff;
                  quo_ff <= {quo_ff[126:0], 1'b1};
               end else begin
                  rem_ff <= r_sh;
                  quo_ff <= {quo_ff[126:0], 1'b0};
               end
               bit_ff <= bit_ff - 7'd1;
               if (bit_ff == 7'd0) st_ff <= S_QUO;
            end
            S_QUO: begin
               if (quo_ff[127:48] != '0) begin
                  term_ff <= MAX48;
                  flag_ff <= 1'b1;
               end else term_ff <= quo_ff[47:0];
               st_ff <= S_ACC;
            end
            S_ACC: begin
               if (sum_w[48]) begin
                  sum_ff <= MAX48;
                  sat_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_w[47:0];
                  sat_ff <= sat_ff | flag_ff;
               end
               if (jb_ff.last) begin
                  op_ff <= OP_WGT;
                  st_ff <= S_LOAD;
               end else st_ff <= S_IDLE;
            end
            S_OUT: if (out_load) begin
               out_ff.total_cost <= sum_ff;
               if (wp_ff[71:64] != '0) begin
                  out_ff.weighted_cost <= MAX48;
                  out_ff.saturated <= 1'b1;
               end else begin
                  out_ff.weighted_cost <= wp_ff[63:16];
                  out_ff.saturated <= sat_ff;
               end
               sum_ff <= '0;
               sat_ff <= 1'b0;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* sv/mahalanobis_collision_cost.sv */
// Top level: inverse Mahalanobis distance collision cost accumulator.
// channel | ports                    | handshake
// req     | req_push/req_full/data   | push & !full
// rsp     | rsp_pop/rsp_empty/data   | pop & !empty
// csr     | csr_write/csr_data       | write
// Item: a step outside the path skips the arithmetic; a singular or zero-distance case
// stops after eight multiplies on one 32x33 unit; else numerator and denominator
// products follow, then the bit-serial 128-bit divide. A last transaction adds the
// weight product and the load of the result slot, and waits while that slot is held.
// Synchronous reset clears sum, flag, queue and result slot.
// A two-entry queue lets the front accept while the back works; one result slot.
`timescale 1ns / 1ps
module mahalanobis_collision_cost import mcc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data,
   input  logic csr_write,
   input  logic [23:0] csr_data
);
   logic [23:0] weight_ff;
   logic job_valid, job_take;
   job_type job;

   always_ff @(posedge clock) begin
      if (reset) weight_ff <= WEIGHT_RESET;
      else if (csr_write) weight_ff <= csr_data;
   end

   mcc_front u_front (.clock, .reset, .req_push, .req_full, .req_data,
      .job_valid, .job_take, .job);
   mcc_back u_back (.clock, .reset, .job_valid, .job_take, .job,
      .weight(weight_ff), .rsp_empty, .rsp_pop, .rsp_data);

`ifndef SYNTHESIS
   a_take: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid) else $error("job taken from empty queue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty) else $error("result lost");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data)) else $error("result changed");
`endif
endmodule

/* sim/mahalanobis_collision_cost_test.sv */
// Testbench: checks the collision cost block against a scoreboard-based predictor.
`timescale 1ns / 1ps
module mahalanobis_collision_cost_test;
   import mcc_pkg::*;

   class cost_scoreboard;
      rsp_type expected_costs[$];
      logic [47:0] cost_sum;
      logic sat_seen;
      logic [23:0] weight;
      int errors;

      function new();
         cost_sum = '0;
         sat_seen = 1'b0;
         weight = WEIGHT_RESET;
         errors = 0;
      endfunction

      task report(string what, logic [47:0] got, logic [47:0] want);
         $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      function void note_request(req_type r);
         logic [8:0] n;
         logic [47:0] term;
         logic flag;
         logic signed [127:0] dx, dy, cxx, cxy, cyx, cyy, det, q;
         logic [127:0] ad, aq, num, den, quo;
         logic [48:0] s;
         logic [71:0] p;
         logic [55:0] w;
         rsp_type e;
         n = (r.path_length > MAX_STEPS) ? 9'(MAX_STEPS) : r.path_length;
         term = '0;
         flag = 1'b0;
         if (r.step_index != 0 && r.step_index < n) begin
            dx = r.traj_x;
            dx = dx - r.mean_x;
            dy = r.traj_y;
            dy = dy - r.mean_y;
            cxx = r.cov_xx;
            cxy = r.cov_xy;
            cyx = r.cov_yx;
            cyy = r.cov_yy;
            det = cxx * cyy - cxy * cyx;
            q = cyy * dx * dx - (cxy + cyx) * dx * dy + cxx * dy * dy;
            if (det == 0) begin
               flag = 1'b1;
            end else if (q == 0) begin
               term = MAX48;
               flag = 1'b1;
            end else begin
               ad = (det < 0) ? -det : det;
               aq = (q < 0) ? -q : q;
               num = (ad * 128'(n - r.step_index)) << FRAC_BITS;
               den = aq * 128'(n);
               quo = num / den;
               if (quo > 128'(MAX48)) begin
                  term = MAX48;
                  flag = 1'b1;
               end else begin
                  term = quo[47:0];
               end
            end
         end
         s = {1'b0, cost_sum} + {1'b0, term};
         if (s > {1'b0, MAX48}) begin
            s = {1'b0, MAX48};
            flag = 1'b1;
         end
         cost_sum = s[47:0];
         if (flag) sat_seen = 1'b1;
         if (r.last) begin
            p = cost_sum * weight;
            w = p[71:16];
            e.total_cost = cost_sum;
            e.saturated = sat_seen;
            if (w > 56'(MAX48)) begin
               e.weighted_cost = MAX48;
               e.saturated = 1'b1;
            end else begin
               e.weighted_cost = w[47:0];
            end
            expected_costs.insert(expected_costs.size(), e);
            cost_sum = '0;
            sat_seen = 1'b0;
         end
      endfunction

      task check_response(rsp_type got);
         rsp_type e;
         if (expected_costs.size() == 0) begin
            report("unexpected transaction", got.total_cost, '0);
         end else begin
            e = expected_costs.pop_front();
            if (got.total_cost !== e.total_cost)
               report("total_cost", got.total_cost, e.total_cost);
            if (got.weighted_cost !== e.weighted_cost)
               report("weighted_cost", got.weighted_cost, e.weighted_cost);
            if (got.saturated !== e.saturated)
               report("saturated", 48'(got.saturated), 48'(e.saturated));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   req_type req_data;
   logic rsp_empty;
   logic rsp_pop;
   rsp_type rsp_data;
   logic csr_write;
   logic [23:0] csr_data;

   cost_scoreboard sb;
   int pop_stall;

   mahalanobis_collision_cost dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_stall = 0;
      end else begin
         if (rsp_pop && !rsp_empty) sb.check_response(rsp_data);
         if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_stall = pick_gap();
         end
      end
   end

   task send_request(req_type r);
      int gap;
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_request(r);
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.expected_costs.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task write_weight(logic [23:0] v);
      csr_write <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.weight = v;
   endtask

   function req_type make_point(logic [7:0] i, logic [8:0] n, logic last, int noisy);
      req_type r;
      if (noisy) begin
         r.traj_x = $urandom;
         r.traj_y = $urandom;
         r.mean_x = $urandom;
         r.mean_y = $urandom;
         r.cov_xx = $urandom;
         r.cov_xy = $urandom;
         r.cov_yx = $urandom;
         r.cov_yy = $urandom;
      end else begin
         r.traj_x = $signed($urandom_range(0, 8000)) - 4000;
         r.traj_y = $signed($urandom_range(0, 8000)) - 4000;
         r.mean_x = $signed($urandom_range(0, 8000)) - 4000;
         r.mean_y = $signed($urandom_range(0, 8000)) - 4000;
         r.cov_xx = $urandom_range(1, 1 << 20);
         r.cov_yy = $urandom_range(1, 1 << 20);
         r.cov_xy = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
         r.cov_yx = ($urandom_range(0, 3) == 0) ? $signed($urandom) : r.cov_xy;
      end
      r.step_index = i;
      r.path_length = n;
      r.last = last;
      return r;
   endfunction

   task random_trajectories(int count);
      int sent, len, noisy;
      logic [8:0] n;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 6);
         n = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(2, 256));
         for (int k = 0; k < len; k++) begin
            noisy = ($urandom_range(0, 5) == 0);
            send_request(make_point(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                    : 8'($urandom_range(1, 255) % (n > 1 ? n : 2)),
                                    n, k == len - 1, noisy));
            sent++;
         end
      end
   endtask

   initial begin
      req_type r;
      logic [23:0] weights[5];
      sb = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_weight(WEIGHT_RESET);
      // step zero, step past path, path clamped to max, single step paths
      send_request(make_point(8'd0, 9'd10, 1'b1, 0));
      send_request(make_point(8'd12, 9'd10, 1'b1, 0));
      send_request(make_point(8'd255, 9'd511, 1'b1, 0));
      send_request(make_point(8'd200, 9'd300, 1'b1, 0));
      send_request(make_point(8'd1, 9'd2, 1'b0, 0));
      send_request(make_point(8'd1, 9'd0, 1'b1, 0));
      // singular covariance
      r = make_point(8'd3, 9'd20, 1'b1, 0);
      r.cov_xx = 32'sd4; r.cov_yy = 32'sd9; r.cov_xy = 32'sd6; r.cov_yx = 32'sd6;
      send_request(r);
      // zero distance
      r = make_point(8'd3, 9'd20, 1'b1, 0);
      r.mean_x = r.traj_x; r.mean_y = r.traj_y;
      send_request(r);
      // term overflow, then sum overflow over several items
      for (int k = 0; k < 3; k++) begin
         r = make_point(8'd1, 9'd256, k == 2, 0);
         r.cov_xx = 32'sd0; r.cov_yy = 32'sd1;
         r.cov_xy = 32'h8000_0000; r.cov_yx = 32'h7FFF_FFFF;
         r.traj_x = 32'sd1; r.mean_x = 32'sd0; r.traj_y = 32'sd0; r.mean_y = 32'sd0;
         send_request(r);
      end
      // extreme coordinates
      r = make_point(8'd5, 9'd256, 1'b1, 0);
      r.traj_x = 32'h7FFF_FFFF; r.mean_x = 32'h8000_0000;
      r.traj_y = 32'h8000_0000; r.mean_y = 32'h7FFF_FFFF;
      r.cov_xx = 32'h7FFF_FFFF; r.cov_yy = 32'h8000_0000;
      r.cov_xy = 32'h7FFF_FFFF; r.cov_yx = 32'h8000_0000;
      send_request(r);
      for (int k = 0; k < 4; k++) send_request(make_point(8'($urandom), 9'($urandom), 1'b1, 1));
      wait_idle();

      weights[0] = 24'd0;
      weights[1] = 24'hFF_FFFF;
      weights[2] = WEIGHT_RESET;
      weights[3] = 24'($urandom);
      weights[4] = 24'($urandom_range(0, 1 << 17));
      foreach (weights[p]) begin
         write_weight(weights[p]);
         if (p == 1) begin
            // saturate the weighted product
            r = make_point(8'd1, 9'd256, 1'b1, 0);
            r.cov_xx = 32'sd0; r.cov_yy = 32'sd1;
            r.cov_xy = 32'h8000_0000; r.cov_yx = 32'h7FFF_FFFF;
            r.traj_x = 32'sd1; r.mean_x = 32'sd0; r.traj_y = 32'sd0; r.mean_y = 32'sd0;
            send_request(r);
         end
         random_trajectories(100);
         wait_idle();
      end

      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
